// File: src/nsrc_pkg.sv
// Package for the nearest sample rate converter: constants, register codes and shared types.
package nsrc_pkg;

  // Storage chunk size in elements and the width of an element offset
  localparam int CHUNK_ELEMENTS = 1024;
  localparam int OFS_W          = (CHUNK_ELEMENTS > 2) ? $clog2(CHUNK_ELEMENTS) : 1;

  // Field widths fixed by the interface
  localparam int STEP_W  = 13;
  localparam int POS_W   = 14;   // holds position plus one step
  localparam int CNT_W   = 24;
  localparam int SMP_W   = 16;
  localparam int COFS_W  = 10;
  localparam int N_W     = 6;
  localparam int CIDX_W  = 2;

  localparam logic [POS_W-1:0] FRAME_ONE   = POS_W'(256);
  localparam logic [N_W-1:0]   MAX_RESULTS = N_W'(32);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_STEP_RATIO   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STEREO       = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WIDE_SAMPLES = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_OUTPUT_TOTAL = 2'd3;

  // Configuration register contents
  typedef struct packed {
    logic [STEP_W-1:0] step_ratio;
    logic              stereo;
    logic              wide_samples;
    logic [CNT_W-1:0]  output_total;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // take the input beat
    logic step;    // emit one output beat
    logic finish;  // close the frame, settle the next position
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic more;       // another output is due for this frame
    logic slot_free;  // output register can take a beat
    logic last;       // the output being emitted ends the frame
  } sts_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

// File: src/nsrc_cfg_regs.sv
// Configuration register file of the nearest sample rate converter.
module nsrc_cfg_regs
  import nsrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_RATIO:   cfg_nxt.step_ratio   = cfg_data[STEP_W-1:0];
        CFG_STEREO:       cfg_nxt.stereo       = cfg_data[0];
        CFG_WIDE_SAMPLES: cfg_nxt.wide_samples = cfg_data[0];
        CFG_OUTPUT_TOTAL: cfg_nxt.output_total = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_ratio   <= STEP_W'(256);
      cfg_r.stereo       <= 1'b0;
      cfg_r.wide_samples <= 1'b1;
      cfg_r.output_total <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/nsrc_datapath.sv
// Datapath: sample conversion, position, count, chunk offset and output register.
module nsrc_datapath
  import nsrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [SMP_W-1:0]   in_first_raw,
  input  logic [SMP_W-1:0]   in_second_raw,
  input  logic               in_new_sound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [SMP_W-1:0] out_left_out,
  output logic signed [SMP_W-1:0] out_right_out,
  output logic [COFS_W-1:0]  out_chunk_offset,
  output logic               out_chunk_start,
  output logic               out_run_last,
  output logic               out_sound_done
);

  // Frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [SMP_W-1:0] left_r, right_r;

  // Output register
  logic             ov_r;
  logic [SMP_W-1:0] ol_r, or_r;
  logic [COFS_W-1:0] oofs_r;
  logic             ostart_r, olast_r, odone_r;

  logic [POS_W-1:0] pos_adv, pos_src, pos_fin;
  logic [CNT_W-1:0] cnt_adv;
  logic [N_W-1:0]   n_adv;
  logic [OFS_W:0]   ofs_sum;
  logic [OFS_W-1:0] ofs_adv;
  logic [31:0]      ofs_ext;
  logic             more_adv;

  // 8-bit unsigned becomes signed 16-bit by flipping the top bit
  function automatic logic [SMP_W-1:0] conv(input logic [SMP_W-1:0] raw, input logic wide);
    logic [SMP_W-1:0] res;
    if (wide) res = raw;
    else      res = {~raw[7], raw[6:0], 8'h00};
    return res;
  endfunction

  // One output step
  assign pos_adv = pos_r + POS_W'(cfg.step_ratio);
  assign cnt_adv = cnt_r + CNT_W'(1);
  assign n_adv   = n_r + N_W'(1);
  assign ofs_sum = {1'b0, ofs_r} + (cfg.stereo ? (OFS_W+1)'(2) : (OFS_W+1)'(1));
  assign ofs_adv = (ofs_sum >= (OFS_W+1)'(CHUNK_ELEMENTS))
                   ? OFS_W'(ofs_sum - (OFS_W+1)'(CHUNK_ELEMENTS))
                   : ofs_sum[OFS_W-1:0];
  assign ofs_ext = 32'(ofs_r);

  assign sts.more      = (pos_r < FRAME_ONE) && (cnt_r < cfg.output_total)
                         && (n_r < MAX_RESULTS);
  assign more_adv      = (pos_adv < FRAME_ONE) && (cnt_adv < cfg.output_total)
                         && (n_adv < MAX_RESULTS);
  assign sts.last      = !more_adv;
  assign sts.slot_free = !ov_r || out_ready;

  // Position left for the next frame, floored at zero
  assign pos_src = cmd.step ? pos_adv : pos_r;
  assign pos_fin = (pos_src >= FRAME_ONE) ? (pos_src - FRAME_ONE) : '0;

  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    ofs_nxt = ofs_r;
    n_nxt   = n_r;
    if (cmd.load) begin
      n_nxt = '0;
      if (in_new_sound) begin
        pos_nxt = '0;
        cnt_nxt = '0;
        ofs_nxt = '0;
      end
    end
    if (cmd.step) begin
      pos_nxt = pos_adv;
      cnt_nxt = cnt_adv;
      ofs_nxt = ofs_adv;
      n_nxt   = n_adv;
    end
    if (cmd.finish) pos_nxt = pos_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
      ofs_r <= '0;
      n_r   <= '0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      ofs_r <= ofs_nxt;
      n_r   <= n_nxt;
      if (cmd.step)     ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // Captured samples and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= conv(in_first_raw, cfg.wide_samples);
      right_r <= cfg.stereo ? conv(in_second_raw, cfg.wide_samples) : '0;
    end
    if (cmd.step) begin
      ol_r     <= left_r;
      or_r     <= right_r;
      oofs_r   <= ofs_ext[COFS_W-1:0];
      ostart_r <= (ofs_r == '0);
      olast_r  <= !more_adv;
      odone_r  <= (cnt_adv == cfg.output_total);
    end
  end

  assign out_valid        = ov_r;
  assign out_left_out     = ol_r;
  assign out_right_out    = or_r;
  assign out_chunk_offset = oofs_r;
  assign out_chunk_start  = ostart_r;
  assign out_run_last     = olast_r;
  assign out_sound_done   = odone_r;

endmodule

// File: src/nsrc_ctrl.sv
// Controller state machine: input acceptance and per-frame output sequencing.
module nsrc_ctrl
  import nsrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.more) begin
          // frame makes no (more) output
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: src/nearest_sample_rate_converter_unit.sv
// Top level of the nearest sample rate converter.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid/in_ready, in_first_raw, ...    | in
//   result  | out_valid/out_ready, out_left_out, ...  | out
//   config  | cfg_valid/cfg_ready, cfg_index/cfg_data | in
//
// A source frame is accepted, then each output beat is stepped through the
// shared position/count adders into the output register until the frame
// ends; a frame with no output makes no beat and only settles the position.
// Reset is synchronous, active low; it restores register defaults and clears
// position, count and chunk offset. A stalled output register holds the
// emit sequence; the next frame is accepted while the last beat still waits.
module nearest_sample_rate_converter_unit
  import nsrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SMP_W-1:0]   in_first_raw,
  input  logic [SMP_W-1:0]   in_second_raw,
  input  logic               in_new_sound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [SMP_W-1:0] out_left_out,
  output logic signed [SMP_W-1:0] out_right_out,
  output logic [COFS_W-1:0]  out_chunk_offset,
  output logic               out_chunk_start,
  output logic               out_run_last,
  output logic               out_sound_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]   cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  nsrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nsrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nsrc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_first_raw     (in_first_raw),
    .in_second_raw    (in_second_raw),
    .in_new_sound     (in_new_sound),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .out_chunk_offset (out_chunk_offset),
    .out_chunk_start  (out_chunk_start),
    .out_run_last     (out_run_last),
    .out_sound_done   (out_sound_done)
  );

endmodule
